/* sv/assert_macros.svh */
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, held off while reset is asserted
`define QP_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// clocked assertion that is also checked during reset
`define QP_ASSERT_ALWAYS(name, prop, msg) \
	name: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* sv/qppm_pkg.sv */
`timescale 1ns / 1ps

package qppm_pkg;

	// request codes on the input channel
	typedef enum logic [1:0] {
		REQ_EDGE_A = 2'd0,
		REQ_EDGE_B = 2'd1,
		REQ_TICK   = 2'd2,
		REQ_CTRL   = 2'd3
	} req_t;

	// configuration register indexes
	typedef enum logic [2:0] {
		CFG_GAIN_P      = 3'd0,
		CFG_GAIN_I      = 3'd1,
		CFG_GAIN_D      = 3'd2,
		CFG_INT_LIMIT   = 3'd3,
		CFG_INT_WINDOW  = 3'd4,
		CFG_DEADBAND    = 3'd5,
		CFG_DUTY_OFFSET = 3'd6,
		CFG_DUTY_MAX    = 3'd7
	} cfg_idx_t;

	// control loop timing and fixed point format
	localparam logic [7:0] TICKS_PER_UPDATE = 8'd2;
	localparam int unsigned GAIN_FRAC_BITS = 8;

	// register reset values
	localparam logic [11:0] RST_GAIN_P      = 12'd512;
	localparam logic [11:0] RST_GAIN_I      = 12'd51;
	localparam logic [11:0] RST_GAIN_D      = 12'd179;
	localparam logic [14:0] RST_INT_LIMIT   = 15'd200;
	localparam logic [14:0] RST_INT_WINDOW  = 15'd20;
	localparam logic [9:0]  RST_DEADBAND    = 10'd5;
	localparam logic [9:0]  RST_DUTY_OFFSET = 10'd200;
	localparam logic [9:0]  RST_DUTY_MAX    = 10'd400;

	localparam logic [7:0] TICK_MAX = 8'd255;

endpackage

/* sv/quadrature_position_pid_motor_unit.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Quadrature encoder position counter with a PID position loop. Encoder edge
// and timer tick transactions update the position and tick count and produce
// no result; a control step transaction produces one result (duty, direction
// and the position it used). One transaction is accepted every clock cycle,
// back to back, whatever the mix of request types, while the result path does
// not stall. A control step updates the loop state and runs the three gain
// multiplies in parallel from the input register; the product register holds
// the products, which are summed, scaled, saturated and shaped into a duty on
// the way to the output register. The output register lets new transactions in
// while a result waits to be taken. Configuration is written through cfg_we,
// cfg_index and cfg_data and must only change while the block is idle.
module quadrature_position_pid_motor_unit
	import qppm_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	// configuration
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [14:0]        cfg_data,
	// request channel
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         req_type,
	input  logic               level_a,
	input  logic               level_b,
	input  logic signed [15:0] setpoint,
	// result channel
	output logic               out_valid,
	input  logic               out_ready,
	output logic [9:0]         duty,
	output logic               direction,
	output logic signed [15:0] position_now
);

	localparam logic signed [30:0] RND_BIAS = 31'((1 << GAIN_FRAC_BITS) - 1);
	localparam logic signed [30:0] PID_POS_MAX = 31'sd32767;
	localparam logic signed [30:0] PID_NEG_MAX = -31'sd32768;

	// configuration registers
	logic [11:0] gain_p_q, gain_i_q, gain_d_q;
	logic [14:0] int_limit_q, int_window_q;
	logic [9:0]  deadband_q, duty_offset_q, duty_max_q;

	// loop state
	logic [15:0] pos_q;
	logic [7:0]  tick_q;
	logic [15:0] err_sum_q;
	logic [15:0] prev_err_q;
	logic [15:0] delta_q;
	logic        dir_q;

	// stage 1: input register
	logic        valid_s1;
	req_t        type_s1;
	logic        lvl_a_s1, lvl_b_s1;
	logic [15:0] setpoint_s1;

	// stage 2: product register
	logic               valid_s2;
	logic signed [28:0] prod_p_s2, prod_i_s2, prod_d_s2;
	logic [15:0]        pos_s2;

	// output register
	logic        out_valid_q;
	logic [9:0]  duty_q;
	logic        dir_out_q;
	logic [15:0] pos_out_q;

	// handshake and stage enables
	logic out_en, s2_free, s1_fire, s1_ctrl;

	assign out_en   = !out_valid_q || out_ready;
	assign s2_free  = !valid_s2 || out_en;
	assign s1_ctrl  = (type_s1 == REQ_CTRL);
	assign s1_fire  = valid_s1 && (!s1_ctrl || s2_free);
	assign in_ready = !valid_s1 || s1_fire;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_p_q      <= RST_GAIN_P;
			gain_i_q      <= RST_GAIN_I;
			gain_d_q      <= RST_GAIN_D;
			int_limit_q   <= RST_INT_LIMIT;
			int_window_q  <= RST_INT_WINDOW;
			deadband_q    <= RST_DEADBAND;
			duty_offset_q <= RST_DUTY_OFFSET;
			duty_max_q    <= RST_DUTY_MAX;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_GAIN_P:      gain_p_q      <= cfg_data[11:0];
				CFG_GAIN_I:      gain_i_q      <= cfg_data[11:0];
				CFG_GAIN_D:      gain_d_q      <= cfg_data[11:0];
				CFG_INT_LIMIT:   int_limit_q   <= cfg_data;
				CFG_INT_WINDOW:  int_window_q  <= cfg_data;
				CFG_DEADBAND:    deadband_q    <= cfg_data[9:0];
				CFG_DUTY_OFFSET: duty_offset_q <= cfg_data[9:0];
				CFG_DUTY_MAX:    duty_max_q    <= cfg_data[9:0];
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			type_s1     <= req_t'(req_type);
			lvl_a_s1    <= level_a;
			lvl_b_s1    <= level_b;
			setpoint_s1 <= setpoint;
		end
	end

	// stage 1: error, integral and derivative update
	logic               do_update;
	logic [15:0]        err_u;
	logic signed [16:0] err_x, win_x, lim_x, sum_raw, sum_clamp;
	logic               in_window;
	logic [15:0]        sum_nxt, delta_nxt;
	logic               step_up;

	assign do_update = (tick_q >= TICKS_PER_UPDATE);
	assign err_u     = setpoint_s1 - pos_q;
	assign err_x     = $signed({err_u[15], err_u});
	assign win_x     = $signed({2'b00, int_window_q});
	assign lim_x     = $signed({2'b00, int_limit_q});
	assign in_window = (err_x > -win_x) && (err_x < win_x);
	assign sum_raw   = $signed({err_sum_q[15], err_sum_q}) + (in_window ? err_x : 17'sd0);

	always_comb begin
		if (sum_raw > lim_x) begin
			sum_clamp = lim_x;
		end else if (sum_raw < -lim_x) begin
			sum_clamp = -lim_x;
		end else begin
			sum_clamp = sum_raw;
		end
	end

	assign sum_nxt   = do_update ? sum_clamp[15:0] : err_sum_q;
	assign delta_nxt = do_update ? (err_u - prev_err_q) : delta_q;

	// encoder direction for an edge on either channel
	assign step_up = (type_s1 == REQ_EDGE_A) ? (lvl_a_s1 == lvl_b_s1) : (lvl_a_s1 != lvl_b_s1);

	// gain multiplies, one each, registered
	logic signed [28:0] prod_p_c, prod_i_c, prod_d_c;

	assign prod_p_c = $signed({1'b0, gain_p_q}) * $signed(err_u);
	assign prod_i_c = $signed({1'b0, gain_i_q}) * $signed(sum_nxt);
	assign prod_d_c = $signed({1'b0, gain_d_q}) * $signed(delta_nxt);

	// loop state update as each transaction leaves stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			tick_q     <= '0;
			err_sum_q  <= '0;
			prev_err_q <= '0;
			delta_q    <= '0;
		end else if (s1_fire) begin
			unique case (type_s1)
				REQ_EDGE_A, REQ_EDGE_B: begin
					pos_q <= step_up ? pos_q + 16'd1 : pos_q - 16'd1;
				end
				REQ_TICK: begin
					if (tick_q != TICK_MAX) begin
						tick_q <= tick_q + 8'd1;
					end
				end
				REQ_CTRL: begin
					if (do_update) begin
						tick_q     <= '0;
						err_sum_q  <= sum_nxt;
						prev_err_q <= err_u;
						delta_q    <= delta_nxt;
					end
				end
			endcase
		end
	end

	// product register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= s1_fire && s1_ctrl;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_free && s1_fire && s1_ctrl) begin
			prod_p_s2 <= prod_p_c;
			prod_i_s2 <= prod_i_c;
			prod_d_s2 <= prod_d_c;
			pos_s2    <= pos_q;
		end
	end

	// stage 2: pid sum, truncate toward zero, saturate
	logic signed [30:0] acc, acc_adj, pid_full;
	logic signed [15:0] pid_sat;
	logic [15:0]        mag;
	logic [16:0]        mag_off;
	logic [9:0]         duty_nxt;
	logic               dir_nxt;

	assign acc      = 31'(prod_p_s2) + 31'(prod_i_s2) + 31'(prod_d_s2);
	assign acc_adj  = acc + (acc[30] ? RND_BIAS : 31'sd0);
	assign pid_full = acc_adj >>> GAIN_FRAC_BITS;

	always_comb begin
		if (pid_full > PID_POS_MAX) begin
			pid_sat = 16'sh7fff;
		end else if (pid_full < PID_NEG_MAX) begin
			pid_sat = 16'sh8000;
		end else begin
			pid_sat = pid_full[15:0];
		end
	end

	// direction holds on a zero output
	always_comb begin
		if (pid_sat > 16'sd0) begin
			dir_nxt = 1'b1;
		end else if (pid_sat < 16'sd0) begin
			dir_nxt = 1'b0;
		end else begin
			dir_nxt = dir_q;
		end
	end

	// magnitude, friction offset above the deadband, cap
	assign mag      = pid_sat[15] ? 16'(-pid_sat) : 16'(pid_sat);
	assign mag_off  = {1'b0, mag} + ((mag > {6'b0, deadband_q}) ? {7'b0, duty_offset_q} : 17'd0);
	assign duty_nxt = (mag_off > {7'b0, duty_max_q}) ? duty_max_q : mag_off[9:0];

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			dir_q       <= 1'b0;
		end else if (out_en) begin
			out_valid_q <= valid_s2;
			if (valid_s2) begin
				dir_q <= dir_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_en && valid_s2) begin
			duty_q    <= duty_nxt;
			dir_out_q <= dir_nxt;
			pos_out_q <= pos_s2;
		end
	end

	assign out_valid    = out_valid_q;
	assign duty         = duty_q;
	assign direction    = dir_out_q;
	assign position_now = pos_out_q;

	// a control step leaving stage 1 always lands in the product register
	`QP_ASSERT(a_ctrl_to_s2, s1_fire && s1_ctrl |=> valid_s2, "control step lost after stage 1")

	// an update step clears the tick count
	`QP_ASSERT(a_tick_clear, s1_fire && s1_ctrl && do_update |=> tick_q == 8'd0, "tick count not cleared")

	// the delivered duty never exceeds the cap
	`QP_ASSERT(a_duty_cap, out_valid_q |-> duty_q <= duty_max_q, "duty above cap")

	// a held product stage is not dropped while the output stalls
	`QP_ASSERT(a_s2_hold, valid_s2 && !out_en |=> valid_s2 && $stable(pos_s2), "product stage lost")

endmodule
